@@ sv/tilbm_pkg.sv @@
package tilbm_pkg;

  localparam int ADC_BITS_DEF = 16;

  localparam logic [7:0]  MAX_SERVO_RST = 8'd106;
  localparam logic [15:0] DIP_HOLD_RST  = 16'd5000;
  localparam logic [15:0] IDLE_LOCK_RST = 16'd20000;
  localparam logic [12:0] LOW_BAT_RST   = 13'd3072;

  localparam logic [2:0] CFG_MAX_SERVO = 3'd0;
  localparam logic [2:0] CFG_TURBO     = 3'd1;
  localparam logic [2:0] CFG_DIP_HOLD  = 3'd2;
  localparam logic [2:0] CFG_IDLE_LOCK = 3'd3;
  localparam logic [2:0] CFG_LOW_BAT   = 3'd4;

  localparam logic [15:0] DEN_BAT   = 16'd25;
  localparam logic [15:0] DEN_VOLT  = 16'd35750;
  localparam logic [15:0] DEN_TEN   = 16'd10;
  localparam logic [15:0] DEN_SPAN  = 16'd33500;
  localparam logic [15:0] DEN_PCT   = 16'd100;
  localparam logic [15:0] DEN_ANIM  = 16'd1536;

  // floor(2^32 / den): quotient estimate is exact or one low
  localparam logic [31:0] RCP_BAT  = 32'(64'd4294967296 / 64'd25);
  localparam logic [31:0] RCP_VOLT = 32'(64'd4294967296 / 64'd35750);
  localparam logic [31:0] RCP_TEN  = 32'(64'd4294967296 / 64'd10);
  localparam logic [31:0] RCP_SPAN = 32'(64'd4294967296 / 64'd33500);
  localparam logic [31:0] RCP_PCT  = 32'(64'd4294967296 / 64'd100);
  localparam logic [31:0] RCP_ANIM = 32'(64'd4294967296 / 64'd1536);

  localparam logic signed [31:0] VOLT_OFFSET = 32'sd10982400;
  localparam logic [15:0] THR_LOW    = 16'd16000;
  localparam logic [7:0]  SERVO_MIN  = 8'd92;
  localparam logic [7:0]  SERVO_TOP  = 8'd180;
  localparam logic [7:0]  SERVO_IDLE = 8'd90;
  localparam logic signed [14:0] THREE_VOLTS = 15'sd768;
  localparam logic [5:0]  ANIM_BASE  = 6'd20;

  localparam logic [2:0] TXT_NONE   = 3'd0;
  localparam logic [2:0] TXT_ACTIVE = 3'd1;
  localparam logic [2:0] TXT_READY  = 3'd2;
  localparam logic [2:0] TXT_TURBO  = 3'd3;
  localparam logic [2:0] TXT_LOCKED = 3'd4;

  localparam logic [1:0] NDL_SINGLE = 2'd0;
  localparam logic [1:0] NDL_LIVE   = 2'd1;
  localparam logic [1:0] NDL_HELD   = 2'd2;

  localparam logic [1:0] LED_OFF     = 2'd0;
  localparam logic [1:0] LED_FULL    = 2'd1;
  localparam logic [1:0] LED_BREATHE = 2'd2;

  typedef enum logic [2:0] {
    STEP_BAT, STEP_VOLT, STEP_PRE, STEP_READ, STEP_THR, STEP_SERVO, STEP_ANIM
  } div_step_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_DIV, ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
    logic [31:0] rcp;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [15:0] rem;
  } div_rsp_t;

endpackage

@@ sv/tilbm_if.sv @@
interface tilbm_in_if;
  logic        valid;
  logic        ready;
  logic        button_pressed;
  logic [15:0] battery_sample;
  logic [15:0] throttle_sample;
  logic [31:0] now_ms;
  modport source (output valid, button_pressed, battery_sample, throttle_sample, now_ms,
                  input ready);
  modport sink (input valid, button_pressed, battery_sample, throttle_sample, now_ms,
                output ready);
endinterface

interface tilbm_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         servo_angle;
  logic [14:0]        throttle_level;
  logic [5:0]         animation_rate;
  logic signed [13:0] volts_main;
  logic signed [13:0] volts_second;
  logic [1:0]         needle_mode;
  logic signed [13:0] dip_delta;
  logic [2:0]         panel_text;
  logic               locked;
  logic               backlight_on;
  logic [1:0]         led_mode;
  modport source (output valid, servo_angle, throttle_level, animation_rate, volts_main,
                  volts_second, needle_mode, dip_delta, panel_text, locked,
                  backlight_on, led_mode, input ready);
  modport sink (input valid, servo_angle, throttle_level, animation_rate, volts_main,
                volts_second, needle_mode, dip_delta, panel_text, locked,
                backlight_on, led_mode, output ready);
endinterface

@@ sv/throttle_interlock_battery_monitor.sv @@
// Sequence: 7 constant divisions on one shared reciprocal-multiply unit, each as a load,
//   the unit's estimate, back-multiply and correction steps, and a capture, then one
//   commit; the commit waits while the previous result stays unread.
// One transaction at a time: in_ready is low from accept until commit.
// Reset (rst_n low, synchronous) restores configuration registers to defaults and clears filters,
//   needles, timers and interlock flags; released flag resets to one.
module throttle_interlock_battery_monitor #(
  parameter int ADC_BITS = tilbm_pkg::ADC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tilbm_in_if.sink    in_ch,
  tilbm_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [7:0]  max_servo_r;
  logic        turbo_r;
  logic [15:0] dip_hold_r;
  logic [15:0] idle_lock_r;
  logic [12:0] low_bat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_servo_r <= tilbm_pkg::MAX_SERVO_RST;
      turbo_r     <= 1'b0;
      dip_hold_r  <= tilbm_pkg::DIP_HOLD_RST;
      idle_lock_r <= tilbm_pkg::IDLE_LOCK_RST;
      low_bat_r   <= tilbm_pkg::LOW_BAT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        tilbm_pkg::CFG_MAX_SERVO: max_servo_r <= cfg_data[7:0];
        tilbm_pkg::CFG_TURBO:     turbo_r     <= cfg_data[0];
        tilbm_pkg::CFG_DIP_HOLD:  dip_hold_r  <= cfg_data;
        tilbm_pkg::CFG_IDLE_LOCK: idle_lock_r <= cfg_data;
        tilbm_pkg::CFG_LOW_BAT:   low_bat_r   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // sequencer
  tilbm_pkg::seq_state_t state_r, state_nxt;
  tilbm_pkg::div_step_t  step_r, step_nxt;
  tilbm_pkg::div_req_t   dreq;
  tilbm_pkg::div_rsp_t   drsp;

  logic        out_free;
  logic        in_acc;
  logic        commit;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign commit   = (state_r == tilbm_pkg::ST_FIN) && out_free;
  assign in_ch.ready = (state_r == tilbm_pkg::ST_IDLE);

  // latched transaction
  logic        btn_r;
  logic [15:0] bat_r, thr_r;
  logic [31:0] now_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      btn_r <= in_ch.button_pressed;
      bat_r <= 16'(in_ch.battery_sample[ADC_BITS-1:0]) << (16 - ADC_BITS);
      thr_r <= 16'(in_ch.throttle_sample[ADC_BITS-1:0]) << (16 - ADC_BITS);
      now_r <= in_ch.now_ms;
    end
  end

  // filter / needle / interlock state
  logic [23:0]        bf_r;
  logic signed [13:0] mv_r, sv_r, hd_r, sd_r;
  logic [31:0]        drt_r, lat_r;
  logic [15:0]        tp_r;
  logic [14:0]        tf_r;
  logic               bp_r, rel_r, lk_r, ss_r;

  // per-item intermediate results
  logic [23:0]        bf_new_r;
  logic signed [13:0] rv_r;
  logic               vneg_r;
  logic [15:0]        tp_new_r;
  logic [6:0]         rd_r;
  logic [14:0]        tf_new_r;
  logic [7:0]         srv_r;
  logic [5:0]         anim_r;

  logic [7:0]         maxa;
  logic signed [31:0] vnum;
  logic [15:0]        tp_over;

  always_comb begin
    maxa = max_servo_r;
    if (maxa < tilbm_pkg::SERVO_MIN) maxa = tilbm_pkg::SERVO_MIN;
    if (maxa > tilbm_pkg::SERVO_TOP) maxa = tilbm_pkg::SERVO_TOP;
  end

  assign vnum    = $signed({8'd0, bf_new_r}) * 32'sd11 - tilbm_pkg::VOLT_OFFSET;
  assign tp_over = tp_new_r - tilbm_pkg::THR_LOW;

  always_comb begin
    dreq.start = (state_r == tilbm_pkg::ST_LOAD);
    dreq.num   = '0;
    dreq.den   = tilbm_pkg::DEN_BAT;
    dreq.rcp   = tilbm_pkg::RCP_BAT;
    case (step_r)
      tilbm_pkg::STEP_BAT: begin
        dreq.num = 32'(bf_r) * 32'd24 + 32'(bat_r) * 32'd256;
        dreq.den = tilbm_pkg::DEN_BAT;
        dreq.rcp = tilbm_pkg::RCP_BAT;
      end
      tilbm_pkg::STEP_VOLT: begin
        dreq.num = vnum[31] ? 32'(-vnum) : 32'(vnum);
        dreq.den = tilbm_pkg::DEN_VOLT;
        dreq.rcp = tilbm_pkg::RCP_VOLT;
      end
      tilbm_pkg::STEP_PRE: begin
        dreq.num = 32'(tp_r) * 32'd9 + 32'(thr_r);
        dreq.den = tilbm_pkg::DEN_TEN;
        dreq.rcp = tilbm_pkg::RCP_TEN;
      end
      tilbm_pkg::STEP_READ: begin
        dreq.num = (tp_new_r > tilbm_pkg::THR_LOW) ? 32'(tp_over) * 32'd100 : 32'd0;
        dreq.den = tilbm_pkg::DEN_SPAN;
        dreq.rcp = tilbm_pkg::RCP_SPAN;
      end
      tilbm_pkg::STEP_THR: begin
        dreq.num = 32'(tf_r) * 32'd7 + 32'(rd_r) * 32'd768;
        dreq.den = tilbm_pkg::DEN_TEN;
        dreq.rcp = tilbm_pkg::RCP_TEN;
      end
      tilbm_pkg::STEP_SERVO: begin
        dreq.num = 32'(tf_new_r[14:8]) * 32'(maxa - tilbm_pkg::SERVO_MIN);
        dreq.den = tilbm_pkg::DEN_PCT;
        dreq.rcp = tilbm_pkg::RCP_PCT;
      end
      tilbm_pkg::STEP_ANIM: begin
        dreq.num = 32'(tf_new_r);
        dreq.den = tilbm_pkg::DEN_ANIM;
        dreq.rcp = tilbm_pkg::RCP_ANIM;
      end
      default: ;
    endcase
  end

  tilbm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      tilbm_pkg::ST_IDLE: if (in_acc) begin
        state_nxt = tilbm_pkg::ST_LOAD;
        step_nxt  = tilbm_pkg::STEP_BAT;
      end
      tilbm_pkg::ST_LOAD: state_nxt = tilbm_pkg::ST_DIV;
      tilbm_pkg::ST_DIV: if (drsp.done) begin
        if (step_r == tilbm_pkg::STEP_ANIM) begin
          state_nxt = tilbm_pkg::ST_FIN;
        end else begin
          state_nxt = tilbm_pkg::ST_LOAD;
          step_nxt  = tilbm_pkg::div_step_t'(step_r + 3'd1);
        end
      end
      tilbm_pkg::ST_FIN: if (out_free) state_nxt = tilbm_pkg::ST_IDLE;
      default: state_nxt = tilbm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tilbm_pkg::ST_IDLE;
      step_r  <= tilbm_pkg::STEP_BAT;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // capture quotients
  logic [8:0] servo_sum;
  assign servo_sum = 9'(tilbm_pkg::SERVO_MIN) + 9'(drsp.quo[7:0]);

  always_ff @(posedge clk) begin
    if (state_r == tilbm_pkg::ST_LOAD && step_r == tilbm_pkg::STEP_VOLT) vneg_r <= vnum[31];
    if (state_r == tilbm_pkg::ST_DIV && drsp.done) begin
      case (step_r)
        tilbm_pkg::STEP_BAT:  bf_new_r <= drsp.quo[23:0];
        tilbm_pkg::STEP_VOLT: begin
          // floor for a negative numerator
          if (vneg_r) rv_r <= -($signed(drsp.quo[13:0]) + 14'(drsp.rem != 16'd0));
          else        rv_r <= $signed(drsp.quo[13:0]);
        end
        tilbm_pkg::STEP_PRE:  tp_new_r <= drsp.quo[15:0];
        tilbm_pkg::STEP_READ: rd_r <= (drsp.quo > 32'd100) ? 7'd100 : drsp.quo[6:0];
        tilbm_pkg::STEP_THR:  tf_new_r <= drsp.quo[14:0];
        tilbm_pkg::STEP_SERVO: srv_r <= (servo_sum > 9'(maxa)) ? maxa : servo_sum[7:0];
        tilbm_pkg::STEP_ANIM: anim_r <= tilbm_pkg::ANIM_BASE + drsp.quo[5:0];
        default: ;
      endcase
    end
  end

  // commit logic
  logic signed [13:0] mv, sv, hd, sd, delta;
  logic [31:0]        drt, lat;
  logic               rel, lk, ss, dbl, ext, act, lowbat;
  logic [2:0]         text;
  logic [1:0]         needle, led;
  logic               bl;
  logic [7:0]         servo;
  logic [5:0]         anim;

  always_comb begin
    mv = mv_r; sv = sv_r; hd = hd_r; sd = sd_r;
    drt = drt_r; lat = lat_r;
    rel = rel_r; lk = lk_r; ss = ss_r;
    ext = 1'b0;
    delta = '0;

    if (!bp_r && btn_r) sv = mv;

    dbl = btn_r && !lk;
    if (!dbl) begin
      mv = rv_r;
      if ((now_r - drt) < 32'(dip_hold_r) && !lk) begin
        sv  = hd;
        dbl = 1'b1;
        ext = 1'b1;
      end else begin
        sv = rv_r;
      end
    end else begin
      if (rv_r < mv) mv = rv_r;
      hd  = mv;
      drt = now_r;
    end

    act = tf_new_r[14:8] != 7'd0;
    if ((btn_r || act) && rel) rel = 1'b0;
    if (!btn_r && !act && !rel) begin
      lk  = 1'b0;
      rel = 1'b1;
    end

    servo = (!lk && btn_r) ? srv_r : tilbm_pkg::SERVO_IDLE;

    if (!lk) text = btn_r ? tilbm_pkg::TXT_ACTIVE
                          : (turbo_r ? tilbm_pkg::TXT_TURBO : tilbm_pkg::TXT_READY);
    else     text = tilbm_pkg::TXT_NONE;

    if (dbl) begin
      if (!ext) sd = 14'(mv - sv);
      delta = sd;
    end
    needle = !dbl ? tilbm_pkg::NDL_SINGLE : (ext ? tilbm_pkg::NDL_HELD : tilbm_pkg::NDL_LIVE);

    if (btn_r || act) begin
      lat = now_r;
      ss  = 1'b0;
    end
    if ((now_r - lat) > 32'(idle_lock_r) && !ss) begin
      ss   = 1'b1;
      lk   = 1'b1;
      text = tilbm_pkg::TXT_LOCKED;
    end

    anim = (btn_r && !lk) ? anim_r : 6'd0;

    lowbat = (15'(mv) < $signed({2'b00, low_bat_r})) && (15'(mv) > tilbm_pkg::THREE_VOLTS);
    if (lowbat) begin
      bl  = now_r[7];
      led = bl ? tilbm_pkg::LED_OFF : tilbm_pkg::LED_FULL;
    end else begin
      bl  = 1'b1;
      led = btn_r ? tilbm_pkg::LED_OFF : tilbm_pkg::LED_BREATHE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bf_r  <= '0;
      mv_r  <= '0;
      sv_r  <= '0;
      hd_r  <= '0;
      sd_r  <= '0;
      drt_r <= '0;
      lat_r <= '0;
      tp_r  <= '0;
      tf_r  <= '0;
      bp_r  <= 1'b0;
      rel_r <= 1'b1;
      lk_r  <= 1'b0;
      ss_r  <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (commit) begin
        bf_r  <= bf_new_r;
        mv_r  <= mv;
        sv_r  <= sv;
        hd_r  <= hd;
        sd_r  <= sd;
        drt_r <= drt;
        lat_r <= lat;
        tp_r  <= tp_new_r;
        tf_r  <= tf_new_r;
        bp_r  <= btn_r;
        rel_r <= rel;
        lk_r  <= lk;
        ss_r  <= ss;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ch.servo_angle    <= servo;
      out_ch.throttle_level <= lk ? 15'd0 : tf_new_r;
      out_ch.animation_rate <= anim;
      out_ch.volts_main     <= mv;
      out_ch.volts_second   <= sv;
      out_ch.needle_mode    <= needle;
      out_ch.dip_delta      <= delta;
      out_ch.panel_text     <= text;
      out_ch.locked         <= lk;
      out_ch.backlight_on   <= bl;
      out_ch.led_mode       <= led;
    end
  end

endmodule

@@ sv/tilbm_div.sv @@
// constant-divisor unit on one shared 32x32 multiplier: reciprocal estimate,
// back-multiply, then one compare and subtract
module tilbm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  tilbm_pkg::div_req_t req,
  output tilbm_pkg::div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] num_r, num_nxt;
  logic [31:0] rcp_r, rcp_nxt;
  logic [15:0] den_r, den_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] prd_r, prd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] diff;

  assign mul_a = (cnt_r == 2'd0) ? num_r : quo_r;
  assign mul_b = (cnt_r == 2'd0) ? rcp_r : {16'd0, den_r};
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign diff  = num_r - prd_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rcp_nxt  = rcp_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    prd_nxt  = prd_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.num;
      rcp_nxt  = req.rcp;
      den_nxt  = req.den;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 2'd1;
      case (cnt_r)
        2'd0: quo_nxt = mul_p[63:32];
        2'd1: prd_nxt = mul_p[31:0];
        default: begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          // estimate may be one low
          if (diff >= 32'(den_r)) begin
            quo_nxt = quo_r + 32'd1;
            rem_nxt = 16'(diff - 32'(den_r));
          end else begin
            rem_nxt = diff[15:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rcp_r <= rcp_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    prd_r <= prd_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ sv/tilbm_chk.sv @@
module tilbm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         servo_angle,
  input logic [14:0]        throttle_level,
  input logic [5:0]         animation_rate,
  input logic signed [13:0] volts_main,
  input logic signed [13:0] volts_second,
  input logic [1:0]         needle_mode,
  input logic signed [13:0] dip_delta,
  input logic               locked
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(servo_angle) && $stable(volts_main))
    else $error("result changed while stalled");

  // an accepted transaction keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_lock_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && locked |-> throttle_level == 15'd0 && servo_angle == 8'd90
                            && animation_rate == 6'd0)
    else $error("locked result not neutral");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && needle_mode == 2'd0 |-> dip_delta == 14'sd0 && volts_main == volts_second)
    else $error("single needle shows a dip");

  a_servo_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> servo_angle >= 8'd90 && servo_angle <= 8'd180)
    else $error("servo angle out of range");

endmodule

bind throttle_interlock_battery_monitor tilbm_chk u_tilbm_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .servo_angle   (out_ch.servo_angle),
  .throttle_level(out_ch.throttle_level),
  .animation_rate(out_ch.animation_rate),
  .volts_main    (out_ch.volts_main),
  .volts_second  (out_ch.volts_second),
  .needle_mode   (out_ch.needle_mode),
  .dip_delta     (out_ch.dip_delta),
  .locked        (out_ch.locked)
);
